FILE: design/differential_drive_odometry_step_unit_assert.svh
// Assertion macros for the odometry step unit checker
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_STEP_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_STEP_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define DDO_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/ddo_pkg.sv
// Shared types and constants for the odometry step unit
`timescale 1ns / 1ps
package ddo_pkg;
   localparam logic [31:0] RAD_TO_BAM = 32'd683565276;
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_SQRT, ST_TURN, ST_CORDIC, ST_MULX, ST_MULY, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CSR_TURN_GAIN = 2'd0, CSR_START_X = 2'd1, CSR_START_Y = 2'd2, CSR_START_HEADING = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        start;
      logic [31:0] ang;
   } cordic_ctl_type;

   typedef struct packed {
      logic               done;
      logic signed [33:0] cs;
      logic signed [33:0] sn;
   } cordic_sts_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051D; 5'd2: r = 32'h09FB385B;
         5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
         5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
         5'd9: r = 32'h00145F2E; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517; 5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145; 5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005; 5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
         default: r = 32'h0;
      endcase
      return r;
   endfunction
endpackage

FILE: design/ddo_stream_if.sv
// Valid/ready channel interface carrying a parameterized payload
`timescale 1ns / 1ps
interface ddo_stream_if #(parameter int WIDTH = 192);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/differential_drive_odometry_step_unit.sv
// Top level of the differential-drive odometry step unit
`timescale 1ns / 1ps
// One request beat carries both wheels' displacement vectors for one tick; the
// unit answers with one response beat holding the new pose, heading and the
// position change. Processing is sequential: one beat at a time, req ready
// only when idle. The distance path runs a prep step, a bit-serial square
// root when the combined magnitude is needed, and the turn multiplication;
// then the CORDIC rotation, the two distance products and the pose update.
// When the forward components are equal, the square root and turn steps are
// skipped. The response is held in a register until it is taken, and the
// next request is accepted only after it is delivered. Writes to start_x,
// start_y and start_heading also load the pose at once. Positions are Q16.16
// and saturate; the heading is a 32-bit binary angle that wraps.
module differential_drive_odometry_step_unit #(
   parameter int FRAC_BITS       = 16,
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ddo_stream_if.sink   req,
   ddo_stream_if.source rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import ddo_pkg::*;

   state_type state_ff, state_in;
   logic [31:0] gain_ff, sx_ff, sy_ff, hd_ff;
   logic signed [31:0] lx, ly, lz, rx, ry, rz;
   logic signed [31:0] ly_ff, ry_ff, dist_ff;
   logic [69:0]  vsq_ff;       // sum of three squared 33-bit magnitudes
   logic         big_ff;       // use the vector magnitude
   logic [34:0]  root_ff;
   logic [5:0]   bit_ff;
   logic [63:0]  p_ff;
   logic [63:0]  tlo_ff;       // low half of gain*|diff| times the radian scale
   logic signed [65:0] prod_ff;
   logic signed [31:0] vx_ff, vy_ff;
   logic         rsp_valid_ff;
   cordic_ctl_type cctl;
   cordic_sts_type csts;

   assign {rz, ry, rx, lz, ly, lx} = req.data;

   // Magnitude comparison, combinational on the request beat, registered on accept
   logic signed [32:0] ssx, ssy, ssz;
   logic [32:0] msx, msy, msz, fsum;
   logic [65:0] qx, qy, qz, fsq;
   logic [69:0] vsq;
   logic [31:0] alx, aly, alz, arx, ary, arz;
   logic [65:0] lm, rm;
   always_comb begin
      ssx = 33'(lx) + 33'(rx); ssy = 33'(ly) + 33'(ry); ssz = 33'(lz) + 33'(rz);
      msx = ssx[32] ? 33'(-ssx) : 33'(ssx);
      msy = ssy[32] ? 33'(-ssy) : 33'(ssy);
      msz = ssz[32] ? 33'(-ssz) : 33'(ssz);
      qx = msx * msx; qy = msy * msy; qz = msz * msz;
      vsq = 70'(qx) + 70'(qy) + 70'(qz);
      alx = lx[31] ? 32'(-lx) : 32'(lx); aly = ly[31] ? 32'(-ly) : 32'(ly);
      alz = lz[31] ? 32'(-lz) : 32'(lz); arx = rx[31] ? 32'(-rx) : 32'(rx);
      ary = ry[31] ? 32'(-ry) : 32'(ry); arz = rz[31] ? 32'(-rz) : 32'(rz);
      fsum = 33'(aly) + 33'(ary);
      fsq = fsum * fsum;
      lm = 66'(alx * alx) + 66'(aly * aly) + 66'(alz * alz);
      rm = 66'(arx * arx) + 66'(ary * ary) + 66'(arz * arz);
   end

   // Square root trial for current bit
   logic [34:0] trial;
   logic [69:0] tsq;
   assign trial = root_ff | (35'd1 << bit_ff);
   assign tsq   = trial * trial;

   // Turn angle: the 64-bit product is scaled in two 32-bit halves
   logic signed [32:0] diff;
   logic [31:0] adiff, dturn;
   logic [63:0] thi;
   logic [95:0] tbig;
   assign diff  = 33'(ry_ff) - 33'(ly_ff);
   assign adiff = diff[32] ? 32'(-diff) : 32'(diff);
   assign thi   = p_ff[63:32] * RAD_TO_BAM;
   assign tbig  = 96'(tlo_ff) + {thi, 32'd0};
   assign dturn = tbig[2*FRAC_BITS +: 32];

   logic signed [31:0] v_sat;
   logic signed [35:0] v_sh;
   assign v_sh  = 36'(prod_ff >>> 30);
   assign v_sat = (v_sh > 36'sd2147483647) ? 32'h7FFFFFFF :
                  (v_sh < -36'sd2147483648) ? 32'h80000000 : v_sh[31:0];

   logic signed [32:0] npx, npy;
   assign npx = 33'(signed'(sx_ff)) + 33'(vx_ff);
   assign npy = 33'(signed'(sy_ff)) + 33'(vy_ff);

   ddo_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
      .clock(clock), .reset(reset), .ctl(cctl), .sts(csts));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req.valid && !rsp_valid_ff) state_in = ST_PREP;
         ST_PREP:   state_in = (ly_ff == ry_ff) ? ST_CORDIC : (big_ff ? ST_SQRT : ST_TURN);
         ST_SQRT:   if (bit_ff == 6'd0) state_in = ST_TURN;
         ST_TURN:   if (bit_ff == 6'd1) state_in = ST_CORDIC;
         ST_CORDIC: if (csts.done) state_in = ST_MULX;
         ST_MULX:   if (bit_ff == 6'd1) state_in = ST_MULY;
         ST_MULY:   if (bit_ff == 6'd1) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      cctl.start = 1'b0;
      cctl.ang   = hd_ff;
      if (state_ff == ST_PREP && ly_ff == ry_ff) cctl.start = 1'b1;
      if (state_ff == ST_TURN && bit_ff == 6'd1) begin
         cctl.start = 1'b1;
         cctl.ang   = diff[32] ? hd_ff - dturn : hd_ff + dturn;
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rsp_valid_ff <= 1'b0;
         gain_ff <= 32'd65536; sx_ff <= '0; sy_ff <= '0; hd_ff <= '0;
         bit_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TURN_GAIN:     gain_ff <= csr_write_data;
               CSR_START_X:       sx_ff <= csr_write_data;
               CSR_START_Y:       sy_ff <= csr_write_data;
               CSR_START_HEADING: hd_ff <= csr_write_data;
               default:           gain_ff <= gain_ff;
            endcase
         end
         case (state_ff)
            ST_IDLE: if (req.valid && !rsp_valid_ff) begin
               ly_ff <= ly; ry_ff <= ry; vsq_ff <= vsq;
               big_ff <= 70'(fsq) > vsq;
               dist_ff <= (ly == ry) ? ly : ((lm >= rm) ? ry : ly);
               root_ff <= '0; bit_ff <= 6'd34;
            end
            ST_PREP: begin
               p_ff <= gain_ff * adiff;
               if (!big_ff) bit_ff <= 6'd2;
            end
            ST_SQRT: begin
               if (tsq <= vsq_ff) root_ff <= trial;
               if (bit_ff == 6'd0) begin
                  dist_ff <= ((tsq <= vsq_ff ? trial : root_ff) > 35'h7FFFFFFF) ?
                     32'h7FFFFFFF : 32'((tsq <= vsq_ff) ? trial : root_ff);
                  bit_ff <= 6'd2;
               end else bit_ff <= bit_ff - 1'b1;
            end
            ST_TURN: begin
               if (bit_ff == 6'd1) begin
                  hd_ff <= cctl.ang; bit_ff <= 6'd2;
               end else begin
                  tlo_ff <= p_ff[31:0] * RAD_TO_BAM;
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            ST_CORDIC: begin
               bit_ff <= 6'd2;
               if (csts.done) prod_ff <= 66'(dist_ff) * 66'(csts.cs);
            end
            ST_MULX: begin
               if (bit_ff == 6'd1) begin
                  vx_ff <= v_sat; bit_ff <= 6'd2;
                  prod_ff <= 66'(dist_ff) * 66'(csts.sn);
               end else bit_ff <= bit_ff - 1'b1;
            end
            ST_MULY: begin
               if (bit_ff == 6'd1) vy_ff <= v_sat;
               else bit_ff <= bit_ff - 1'b1;
            end
            ST_DONE: begin
               sx_ff <= (npx > 33'sd2147483647) ? 32'h7FFFFFFF :
                        (npx < -33'sd2147483648) ? 32'h80000000 : npx[31:0];
               sy_ff <= (npy > 33'sd2147483647) ? 32'h7FFFFFFF :
                        (npy < -33'sd2147483648) ? 32'h80000000 : npy[31:0];
               rsp_valid_ff <= 1'b1;
            end
            default: bit_ff <= bit_ff;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = {vy_ff, vx_ff, hd_ff, sy_ff, sx_ff};
endmodule

FILE: design/ddo_cordic.sv
// Iterative CORDIC rotation unit for sine and cosine in Q30
`timescale 1ns / 1ps
module ddo_cordic #(parameter int TRIG_ITERATIONS = 16) (
   input  logic                    clock,
   input  logic                    reset,
   input  ddo_pkg::cordic_ctl_type ctl,
   output ddo_pkg::cordic_sts_type sts
);
   import ddo_pkg::*;
   localparam int CW = $clog2(TRIG_ITERATIONS + 1);

   logic               busy_ff, busy_in, flip_ff, flip_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [31:0]        ang_adj;
   logic [4:0]         idx;
   logic signed [33:0] xs, ys, a;

   assign idx = 5'(cnt_ff);
   assign xs  = x_ff >>> idx;
   assign ys  = y_ff >>> idx;
   assign a   = 34'(atan_bam(idx));

   always_comb begin
      busy_in = busy_ff; cnt_in = cnt_ff; flip_in = flip_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      ang_adj = ctl.ang;
      if (ctl.start) begin
         flip_in = ang_adj[31] ^ ang_adj[30];
         if (flip_in) ang_adj = ang_adj + 32'h80000000;
         x_in = CORDIC_START; y_in = '0;
         z_in = 34'(signed'(ang_adj));
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         // all iterations applied: hold the vector for one done cycle, then stop
         if (cnt_ff == CW'(TRIG_ITERATIONS)) begin
            busy_in = 1'b0;
         end else begin
            if (!z_ff[33]) begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - a;
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + a;
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0; flip_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in; flip_ff <= flip_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
   end

   assign sts.done = busy_ff && (cnt_ff == CW'(TRIG_ITERATIONS));
   assign sts.cs   = flip_ff ? -x_ff : x_ff;
   assign sts.sn   = flip_ff ? -y_ff : y_ff;
endmodule

FILE: design/ddo_checker.sv
// Port-level checker for the odometry step unit, bound to the top level
`timescale 1ns / 1ps
`include "differential_drive_odometry_step_unit_assert.svh"
module ddo_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [159:0] rsp_data
);
   `DDO_ASSERT_IMP(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready, "ready while busy")
   `DDO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accept")
   `DDO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp hold")
endmodule

bind differential_drive_odometry_step_unit ddo_checker u_ddo_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
